>>> hdl/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

	// Every field on the stream ports is one 32-bit word.
	localparam int FIELD_W = 32;

	typedef logic [3:0] func_t;
	typedef logic [1:0] status_t;

	// Operation codes.
	localparam func_t FN_ADD   = 4'd0;
	localparam func_t FN_SUB   = 4'd1;
	localparam func_t FN_SCALE = 4'd2;
	localparam func_t FN_DIV   = 4'd3;
	localparam func_t FN_DOT   = 4'd4;
	localparam func_t FN_CROSS = 4'd5;
	localparam func_t FN_MAGSQ = 4'd6;
	localparam func_t FN_MAG   = 4'd7;
	localparam func_t FN_NORM  = 4'd8;

	// Result status codes.
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_SAT  = 2'd1;
	localparam status_t ST_DIVZ = 2'd2;

endpackage

`default_nettype wire

>>> hdl/v3alu_lane.sv
`default_nettype none

module v3alu_lane #(
	parameter int DW = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire v3alu_pkg::func_t func_s1,
	input  wire logic signed [DW-1:0] a,
	input  wire logic signed [DW-1:0] b,
	input  wire logic signed [DW-1:0] m1x,
	input  wire logic signed [DW-1:0] m1y,
	input  wire logic signed [DW-1:0] m2x,
	input  wire logic signed [DW-1:0] m2y,
	output logic signed [2*DW-1:0] prod_s2,
	output logic signed [DW-1:0] res_s3,
	output logic sat_s3
);
	import v3alu_pkg::*;

	localparam int PW = 2 * DW;
	localparam logic signed [PW:0] LIM_HI = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW:0] LIM_LO = ~LIM_HI;

	func_t func_s2;
	logic signed [PW-1:0] prod2_s2;
	logic [DW:0] sum_s2;
	logic [DW:0] dif_s2;
	logic signed [PW:0] ext1;
	logic signed [PW:0] ext2;
	logic signed [PW:0] cross_w;
	logic signed [PW:0] wide;
	logic signed [DW-1:0] res_d;
	logic sat_d;

	// Two products and the exact sum and difference of this component.
	always_ff @(posedge clk) begin
		if (en) begin
			func_s2  <= func_s1;
			prod_s2  <= m1x * m1y;
			prod2_s2 <= m2x * m2y;
			sum_s2   <= {a[DW-1], a} + {b[DW-1], b};
			dif_s2   <= {a[DW-1], a} - {b[DW-1], b};
		end
	end

	assign ext1 = {prod_s2[PW-1], prod_s2};
	assign ext2 = {prod2_s2[PW-1], prod2_s2};
	assign cross_w = ext1 - ext2;

	// Pick this lane's exact value, drop the fraction toward minus infinity and clamp.
	always_comb begin
		unique case (func_s2)
			FN_ADD:   wide = {{(PW-DW){sum_s2[DW]}}, sum_s2};
			FN_SUB:   wide = {{(PW-DW){dif_s2[DW]}}, dif_s2};
			FN_SCALE: wide = ext1 >>> FRAC_BITS;
			FN_CROSS: wide = cross_w >>> FRAC_BITS;
			default:  wide = '0;
		endcase
		res_d = wide[DW-1:0];
		sat_d = 1'b0;
		if (wide > LIM_HI) begin
			res_d = LIM_HI[DW-1:0];
			sat_d = 1'b1;
		end else if (wide < LIM_LO) begin
			res_d = LIM_LO[DW-1:0];
			sat_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
			sat_s3 <= sat_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/v3alu_sqrt.sv
`default_nettype none

module v3alu_sqrt #(
	parameter int RTW = 32,
	parameter int SBW = 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [2*RTW-1:0] rad,
	input  wire logic [SBW-1:0] sb_in,
	output logic out_valid,
	output logic [RTW-1:0] root,
	output logic [SBW-1:0] sb_out
);

	localparam int RW = 2 * RTW;

	logic vld_q [RTW+1];
	logic [RW-1:0] rad_q [RTW+1];
	logic [RTW+1:0] rem_q [RTW+1];
	logic [RTW-1:0] root_q [RTW+1];
	logic [SBW-1:0] sb_q [RTW+1];

	// Capture stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0]  <= rad;
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			sb_q[0]   <= sb_in;
		end
	end

	// One root bit per stage, taking two radicand bits from the top each time.
	for (genvar k = 1; k <= RTW; k++) begin : g_stage
		logic [RTW+3:0] trial;
		logic [RTW+3:0] tgt;
		logic take;

		assign trial = {rem_q[k-1], rad_q[k-1][RW-1 -: 2]};
		assign tgt = {2'b00, root_q[k-1], 2'b01};
		assign take = (trial >= tgt);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k]  <= rad_q[k-1] << 2;
				rem_q[k]  <= take ? (RTW+2)'(trial - tgt) : trial[RTW+1:0];
				root_q[k] <= {root_q[k-1][RTW-2:0], take};
				sb_q[k]   <= sb_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[RTW];
	assign root = root_q[RTW];
	assign sb_out = sb_q[RTW];

endmodule

`default_nettype wire

>>> hdl/v3alu_div.sv
`default_nettype none

module v3alu_div #(
	parameter int NW = 48,
	parameter int DVW = 32,
	parameter int SBW = 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DVW-1:0] den,
	input  wire logic [SBW-1:0] sb_in,
	output logic out_valid,
	output logic [NW-1:0] quo,
	output logic [SBW-1:0] sb_out
);

	logic vld_q [NW+1];
	logic [NW-1:0] nq_q [NW+1];
	logic [DVW-1:0] rem_q [NW+1];
	logic [DVW-1:0] den_q [NW+1];
	logic [SBW-1:0] sb_q [NW+1];

	// Capture stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_q[0]  <= num;
			rem_q[0] <= '0;
			den_q[0] <= den;
			sb_q[0]  <= sb_in;
		end
	end

	// Restoring division: one quotient bit per stage, shifted in as the numerator shifts out.
	for (genvar k = 1; k <= NW; k++) begin : g_stage
		logic [DVW:0] trial;
		logic take;

		assign trial = {rem_q[k-1], nq_q[k-1][NW-1]};
		assign take = (trial >= {1'b0, den_q[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? DVW'(trial - {1'b0, den_q[k-1]}) : trial[DVW-1:0];
				nq_q[k]  <= {nq_q[k-1][NW-2:0], take};
				den_q[k] <= den_q[k-1];
				sb_q[k]  <= sb_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[NW];
	assign quo = nq_q[NW];
	assign sb_out = sb_q[NW];

endmodule

`default_nettype wire

>>> hdl/vector3_alu_unit.sv
`default_nettype none
// An accepted input beat passes the input registers, the lane registers, the square root
// pipeline, the three divider pipelines and the output register on its way to the result.
// Throughput: one beat per cycle; every operation runs through the bit-per-stage square
// root and divider pipelines, whose depth sets the latency. A waiting output stalls the pipe.
// Reset: arst_n clears all valid flags at once; no result beat is pending after reset.

module vector3_alu_unit #(
	parameter int WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
	input  wire logic [7*v3alu_pkg::FIELD_W-1:0] s_axis_tdata,
	// func
	input  wire v3alu_pkg::func_t s_axis_tuser,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// r_x, r_y, r_z, scalar_out
	output logic [4*v3alu_pkg::FIELD_W-1:0] m_axis_tdata,
	// status
	output v3alu_pkg::status_t m_axis_tuser
);
	import v3alu_pkg::*;

	localparam int DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
	localparam int PW = 2 * DW;
	localparam int NW = DW + FRAC_BITS;
	localparam logic signed [PW+1:0] SUM_HI = {{(PW-DW+3){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW+1:0] SUM_LO = ~SUM_HI;
	localparam logic [PW-1:0] SQ_HI = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] R_HI = {1'b0, {(DW-1){1'b1}}};
	localparam logic [NW-1:0] Q_HI = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [NW-1:0] Q_LO_MAG = Q_HI + 1'b1;

	typedef struct packed {
		func_t func;
		logic [2:0][DW-1:0] a;
		logic [DW-1:0] c;
		logic [2:0][DW-1:0] r;
		logic [DW-1:0] s;
		logic sat;
	} sq_sb_t;

	typedef struct packed {
		logic quo_op;
		logic dz;
		logic [2:0][DW-1:0] r;
		logic [DW-1:0] s;
		logic sat;
		logic sign;
	} dv_sb_t;

	logic en;
	logic vld_s1, vld_s2, vld_s3;
	func_t func_s1, func_s2, func_s3;
	logic signed [DW-1:0] a_s1 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [DW-1:0] c_s1;
	logic signed [DW-1:0] a_s2 [3];
	logic signed [DW-1:0] c_s2;
	logic signed [DW-1:0] a_s3 [3];
	logic signed [DW-1:0] c_s3;
	logic signed [PW-1:0] prod_s2 [3];
	logic signed [DW-1:0] res_s3 [3];
	logic sat_s3 [3];
	logic signed [PW+1:0] sum3_s3;

	logic signed [PW+1:0] dot_sh;
	logic [PW-1:0] sq;
	logic [PW-1:0] sq_sh;
	logic [DW-1:0] s_early;
	logic sat_sc;
	sq_sb_t sb1_in, sb1_out;
	logic vld_r;
	logic [DW-1:0] root;

	logic is_div, is_norm, c_neg, mag_sat;
	logic [DW-1:0] c_abs;
	logic [DW-1:0] den;
	logic [DW-1:0] a_abs [3];
	logic [NW-1:0] num [3];
	logic sgn_in [3];
	dv_sb_t dsb_in, dsb_out;
	logic [NW-1:0] quo [3];
	logic sgn_o [3];
	logic vld_d [3];

	logic [DW-1:0] qv [3];
	logic qsat [3];
	logic [DW-1:0] r_q [3];
	logic [DW-1:0] s_q;
	status_t status_q;

	// The whole pipe moves unless a result beat is waiting at the output.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Valid flags of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Input registers and operand delay for the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= s_axis_tuser;
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= s_axis_tdata[i*FIELD_W +: DW];
				b_s1[i] <= s_axis_tdata[(i+3)*FIELD_W +: DW];
				a_s2[i] <= a_s1[i];
				a_s3[i] <= a_s2[i];
			end
			c_s1 <= s_axis_tdata[6*FIELD_W +: DW];
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			func_s2 <= func_s1;
			func_s3 <= func_s2;
			sum3_s3 <= {{2{prod_s2[0][PW-1]}}, prod_s2[0]}
				+ {{2{prod_s2[1][PW-1]}}, prod_s2[1]}
				+ {{2{prod_s2[2][PW-1]}}, prod_s2[2]};
		end
	end

	// Three component lanes; the operand muxes route the cross-product terms.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		logic signed [DW-1:0] m1x;
		logic signed [DW-1:0] m1y;

		always_comb begin
			m1x = a_s1[i];
			m1y = a_s1[i];
			unique case (func_s1)
				FN_SCALE: m1y = c_s1;
				FN_DOT:   m1y = b_s1[i];
				FN_CROSS: begin
					m1x = a_s1[J];
					m1y = b_s1[K];
				end
				default: ;
			endcase
		end

		v3alu_lane #(
			.DW(DW),
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk(clk),
			.en(en),
			.func_s1(func_s1),
			.a(a_s1[i]),
			.b(b_s1[i]),
			.m1x(m1x),
			.m1y(m1y),
			.m2x(b_s1[J]),
			.m2y(a_s1[K]),
			.prod_s2(prod_s2[i]),
			.res_s3(res_s3[i]),
			.sat_s3(sat_s3[i])
		);
	end

	// Merge: dot product and squared magnitude from the summed lane products.
	assign dot_sh = sum3_s3 >>> FRAC_BITS;
	assign sq = sum3_s3[PW-1:0];
	assign sq_sh = sq >> FRAC_BITS;

	always_comb begin
		s_early = '0;
		sat_sc = 1'b0;
		unique case (func_s3)
			FN_DOT: begin
				if (dot_sh > SUM_HI) begin
					s_early = R_HI;
					sat_sc = 1'b1;
				end else if (dot_sh < SUM_LO) begin
					s_early = ~R_HI;
					sat_sc = 1'b1;
				end else begin
					s_early = dot_sh[DW-1:0];
				end
			end
			FN_MAGSQ: begin
				if (sq_sh > SQ_HI) begin
					s_early = R_HI;
					sat_sc = 1'b1;
				end else begin
					s_early = sq_sh[DW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sb1_in.func = func_s3;
		sb1_in.c = c_s3;
		sb1_in.s = s_early;
		sb1_in.sat = sat_sc | sat_s3[0] | sat_s3[1] | sat_s3[2];
		for (int i = 0; i < 3; i++) begin
			sb1_in.a[i] = a_s3[i];
			sb1_in.r[i] = res_s3[i];
		end
	end

	v3alu_sqrt #(
		.RTW(DW),
		.SBW($bits(sq_sb_t))
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s3),
		.rad(sq),
		.sb_in(sb1_in),
		.out_valid(vld_r),
		.root(root),
		.sb_out(sb1_out)
	);

	// Divider operands: magnitudes and result signs, divisor from scalar_in or the root.
	always_comb begin
		is_div = (sb1_out.func == FN_DIV);
		is_norm = (sb1_out.func == FN_NORM);
		c_neg = sb1_out.c[DW-1];
		c_abs = c_neg ? DW'(-sb1_out.c) : sb1_out.c;
		den = is_div ? c_abs : root;
		mag_sat = (sb1_out.func == FN_MAG) && (root > R_HI);
		for (int i = 0; i < 3; i++) begin
			a_abs[i] = sb1_out.a[i][DW-1] ? DW'(-sb1_out.a[i]) : sb1_out.a[i];
			num[i] = NW'(a_abs[i]) << FRAC_BITS;
			sgn_in[i] = sb1_out.a[i][DW-1] ^ (is_div & c_neg);
		end
		dsb_in.quo_op = is_div || is_norm;
		dsb_in.dz = (is_div && (sb1_out.c == '0)) || (is_norm && (root == '0));
		dsb_in.r = sb1_out.r;
		if (sb1_out.func == FN_MAG) begin
			dsb_in.s = mag_sat ? R_HI : root;
		end else begin
			dsb_in.s = sb1_out.s;
		end
		dsb_in.sat = sb1_out.sat | mag_sat;
		dsb_in.sign = sgn_in[0];
	end

	// Divider lanes; the first one carries the rest of the result along.
	for (genvar i = 0; i < 3; i++) begin : g_div
		if (i == 0) begin : g_main
			v3alu_div #(
				.NW(NW),
				.DVW(DW),
				.SBW($bits(dv_sb_t))
			) u_div (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.in_valid(vld_r),
				.num(num[i]),
				.den(den),
				.sb_in(dsb_in),
				.out_valid(vld_d[i]),
				.quo(quo[i]),
				.sb_out(dsb_out)
			);
			assign sgn_o[i] = dsb_out.sign;
		end else begin : g_side
			v3alu_div #(
				.NW(NW),
				.DVW(DW),
				.SBW(1)
			) u_div (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.in_valid(vld_r),
				.num(num[i]),
				.den(den),
				.sb_in(sgn_in[i]),
				.out_valid(vld_d[i]),
				.quo(quo[i]),
				.sb_out(sgn_o[i])
			);
		end
	end

	// Apply the quotient sign and clamp to the data range.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv[i] = quo[i][DW-1:0];
			qsat[i] = 1'b0;
			if (!sgn_o[i]) begin
				if (quo[i] > Q_HI) begin
					qv[i] = R_HI;
					qsat[i] = 1'b1;
				end
			end else begin
				if (quo[i] > Q_LO_MAG) begin
					qv[i] = ~R_HI;
					qsat[i] = 1'b1;
				end else begin
					qv[i] = DW'(~quo[i][DW-1:0] + 1'b1);
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= vld_d[0] & vld_d[1] & vld_d[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_q <= dsb_out.s;
			if (dsb_out.quo_op) begin
				if (dsb_out.dz) begin
					for (int i = 0; i < 3; i++) begin
						r_q[i] <= '0;
					end
					s_q <= '0;
					status_q <= ST_DIVZ;
				end else begin
					for (int i = 0; i < 3; i++) begin
						r_q[i] <= qv[i];
					end
					status_q <= (qsat[0] | qsat[1] | qsat[2] | dsb_out.sat) ? ST_SAT : ST_OK;
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					r_q[i] <= dsb_out.r[i];
				end
				status_q <= dsb_out.sat ? ST_SAT : ST_OK;
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_out
		assign m_axis_tdata[i*FIELD_W +: FIELD_W] = FIELD_W'($signed(r_q[i]));
	end
	assign m_axis_tdata[3*FIELD_W +: FIELD_W] = FIELD_W'($signed(s_q));
	assign m_axis_tuser = status_q;

endmodule

`default_nettype wire

>>> hdl/v3alu_checker.sv
`default_nettype none

module v3alu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [4*v3alu_pkg::FIELD_W-1:0] m_axis_tdata,
	input wire v3alu_pkg::status_t m_axis_tuser
);
	import v3alu_pkg::*;

	// A waiting result beat stops the input side.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input ready while a result beat waits");

	// With nothing at the output the input side is open.
	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready with an empty output");

	// A divide-by-zero result carries a zero vector and a zero scalar.
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_DIVZ)) |-> (m_axis_tdata == '0))
		else $error("divide-by-zero beat with nonzero data");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result beat changed while stalled");

	// After an accepted input beat, output valid is never unknown.
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !$isunknown(m_axis_tvalid))
		else $error("output valid unknown after an input beat");

endmodule

bind vector3_alu_unit v3alu_checker u_v3alu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

`default_nettype wire
